[hdl/weighted_variance_engine_defines.svh]
// ----------------------------------------------------------------------------
// Weighted variance engine assertion macros
// Shared helpers for concurrent checks on the clock and synchronous reset.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_VARIANCE_ENGINE_DEFINES_SVH
`define WEIGHTED_VARIANCE_ENGINE_DEFINES_SVH

// same-cycle implication
`define WVE_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WVE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/wve_pkg.sv]
// ----------------------------------------------------------------------------
// wve_pkg
// Widths, status codes, register indexes and shared types.
// ----------------------------------------------------------------------------
package wve_pkg;

   localparam int MAX_ITEMS = 1024;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int VAL_W     = 32;
   localparam int ENTRY_W   = 2 * VAL_W;
   localparam int DDOF_W    = 10;
   localparam int TOT_W     = VAL_W - 1 + CNT_W;
   localparam int SMAG_W    = 2 * (VAL_W - 1) + CNT_W;
   localparam int S_W       = SMAG_W + 1;
   localparam int A_W       = 3 * (VAL_W - 1) + CNT_W;
   localparam int P_W       = 2 * (VAL_W - 1) + CNT_W + 1;
   localparam int PR_W      = A_W + SMAG_W;
   localparam int DEN_W     = 2 * TOT_W;
   localparam int IT_W      = $clog2(PR_W);
   localparam int RES_W     = 64;
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [TOT_W-1:0] ONE_Q16 = TOT_W'(65536);

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_UNDEF = 2'd1;
   localparam logic [STAT_W-1:0] ST_NEG   = 2'd2;
   localparam logic [STAT_W-1:0] ST_OVF   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_DDOF = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ROOT = 1'b1;

   typedef struct packed {
      logic signed [S_W-1:0] s;
      logic [A_W-1:0]        a;
      logic [P_W-1:0]        p;
   } wve_sums_type;

endpackage

[hdl/wve_ram.sv]
// ----------------------------------------------------------------------------
// wve_ram
// Sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wve_ram import wve_pkg::*; (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem [MAX_ITEMS];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/wve_accum.sv]
// ----------------------------------------------------------------------------
// wve_accum
// Pass over the stored set: sums of w*v, w*v^2 and w^2 over positive weights.
// ----------------------------------------------------------------------------
module wve_accum import wve_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [CNT_W-1:0]   n_items,
   output logic [ADDR_W-1:0]  rd_addr,
   input  logic [ENTRY_W-1:0] rd_data,
   output wve_sums_type       sums,
   output logic               done
);

   localparam logic [2:0] P_RD  = 3'd0;
   localparam logic [2:0] P_LAT = 3'd1;
   localparam logic [2:0] P_M1  = 3'd2;
   localparam logic [2:0] P_M2  = 3'd3;
   localparam logic [2:0] P_M3  = 3'd4;
   localparam logic [2:0] P_M4  = 3'd5;
   localparam logic [2:0] P_M5  = 3'd6;
   localparam logic [2:0] P_M6  = 3'd7;

   logic [2:0]            ph_ff, ph_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [VAL_W-1:0]      mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [VAL_W-1:0]      wt_ff, wt_in;
   logic [ENTRY_W-1:0]    m2_ff, m2_in;
   logic [ENTRY_W-1:0]    prod_ff, prod_in;
   logic signed [S_W-1:0] s_ff, s_in;
   logic [A_W-1:0]        a_ff, a_in;
   logic [P_W-1:0]        p_ff, p_in;
   logic [VAL_W-1:0]      mul_a, mul_b;
   logic signed [VAL_W-1:0] v_raw, w_raw;
   logic signed [S_W-1:0] term;

   assign v_raw   = rd_data[VAL_W-1:0];
   assign w_raw   = rd_data[ENTRY_W-1:VAL_W];
   assign term    = $signed({{(S_W-ENTRY_W){1'b0}}, prod_ff});
   assign prod_in = ENTRY_W'(mul_a) * ENTRY_W'(mul_b);

   always_comb begin
      unique case (ph_ff)
         P_M1:    begin mul_a = mag_ff;                    mul_b = wt_ff;  end
         P_M2:    begin mul_a = mag_ff;                    mul_b = mag_ff; end
         P_M3:    begin mul_a = wt_ff;                     mul_b = wt_ff;  end
         P_M4:    begin mul_a = m2_ff[VAL_W-1:0];          mul_b = wt_ff;  end
         P_M5:    begin mul_a = m2_ff[ENTRY_W-1:VAL_W];    mul_b = wt_ff;  end
         default: begin mul_a = '0;                        mul_b = '0;     end
      endcase
   end

   always_comb begin
      ph_in   = ph_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      wt_in   = wt_ff;
      m2_in   = m2_ff;
      s_in    = s_ff;
      a_in    = a_ff;
      p_in    = p_ff;
      if (start) begin
         busy_in = 1'b1;
         ph_in   = P_RD;
         idx_in  = '0;
         s_in    = '0;
         a_in    = '0;
         p_in    = '0;
      end else if (busy_ff) begin
         unique case (ph_ff)
            P_RD: begin
               if (idx_ff == n_items) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  ph_in = P_LAT;
               end
            end
            P_LAT: begin
               if (w_raw <= 0) begin
                  idx_in = idx_ff + 1'b1;
                  ph_in  = P_RD;
               end else begin
                  neg_in = v_raw[VAL_W-1];
                  mag_in = v_raw[VAL_W-1] ? VAL_W'(-v_raw) : VAL_W'(v_raw);
                  wt_in  = VAL_W'(w_raw);
                  ph_in  = P_M1;
               end
            end
            P_M1: ph_in = P_M2;
            P_M2: begin
               s_in  = neg_ff ? s_ff - term : s_ff + term;
               ph_in = P_M3;
            end
            P_M3: begin
               m2_in = prod_ff;
               ph_in = P_M4;
            end
            P_M4: begin
               p_in  = p_ff + P_W'(prod_ff);
               ph_in = P_M5;
            end
            P_M5: begin
               a_in  = a_ff + A_W'(prod_ff);
               ph_in = P_M6;
            end
            P_M6: begin
               a_in   = a_ff + (A_W'(prod_ff) << VAL_W);
               idx_in = idx_ff + 1'b1;
               ph_in  = P_RD;
            end
            default: ph_in = P_RD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= P_RD;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      idx_ff  <= idx_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      wt_ff   <= wt_in;
      m2_ff   <= m2_in;
      prod_ff <= prod_in;
      s_ff    <= s_in;
      a_ff    <= a_in;
      p_ff    <= p_in;
   end

   assign rd_addr = idx_ff[ADDR_W-1:0];
   assign sums    = '{s: s_ff, a: a_ff, p: p_ff};
   assign done    = done_ff;

endmodule

[hdl/wve_finish.sv]
// ----------------------------------------------------------------------------
// wve_finish
// Closing arithmetic: shift-add products, restoring divide, digit square root.
// ----------------------------------------------------------------------------
module wve_finish import wve_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  wve_sums_type      sums,
   input  logic [TOT_W-1:0]  wtot,
   input  logic [DDOF_W-1:0] ddof,
   input  logic              root_mode,
   output logic              done,
   output logic [RES_W-1:0]  result,
   output logic [STAT_W-1:0] status
);

   localparam logic [3:0] F_IDLE = 4'd0;
   localparam logic [3:0] F_PREP = 4'd1;
   localparam logic [3:0] F_LNCH = 4'd2;
   localparam logic [3:0] F_MUL  = 4'd3;
   localparam logic [3:0] F_POST = 4'd4;
   localparam logic [3:0] F_DIV  = 4'd5;
   localparam logic [3:0] F_RND  = 4'd6;
   localparam logic [3:0] F_FIN  = 4'd7;
   localparam logic [3:0] F_SQRT = 4'd8;
   localparam logic [3:0] F_SRND = 4'd9;
   localparam logic [3:0] F_OUT  = 4'd10;

   localparam logic [1:0] OP_DEN  = 2'd0;
   localparam logic [1:0] OP_CORR = 2'd1;
   localparam logic [1:0] OP_NUM  = 2'd2;
   localparam logic [1:0] OP_SSQ  = 2'd3;

   localparam int SQ_W = 2 * RES_W;
   localparam int SR_W = RES_W + 2;
   localparam int RT_W = RES_W + 1;
   localparam int QS_W = SQ_W - VAL_W;

   logic [3:0]              st_ff, st_in;
   logic [1:0]              op_ff, op_in;
   logic [IT_W-1:0]         cnt_ff, cnt_in;
   logic [TOT_W-1:0]        weff_ff, weff_in;
   logic [P_W-1:0]          p_ff, p_in;
   logic [SMAG_W-1:0]       smag_ff, smag_in;
   logic [A_W-1:0]          x_ff, x_in;
   logic [SMAG_W-1:0]       y_ff, y_in;
   logic [PR_W-1:0]         acc_ff, acc_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic [PR_W-1:0]         num_ff, num_in;
   logic [DEN_W-1:0]        rem_ff, rem_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic [SR_W-1:0]         srem_ff, srem_in;
   logic [RT_W-1:0]         root_ff, root_in;
   logic [RES_W-1:0]        res_ff, res_in;
   logic [STAT_W-1:0]       status_ff, status_in;

   logic [16:0]             z;
   logic [33:0]             zsq;
   logic [DEN_W:0]          rem_sh;
   logic                    div_ge;
   logic [SR_W-1:0]         srem_sh, trial;
   logic                    sq_ge;
   logic [RT_W-1:0]         root_rnd;

   assign z       = 17'(ONE_Q16 - wtot);
   assign zsq     = {17'b0, z} * {17'b0, z};
   assign rem_sh  = {rem_ff, num_ff[PR_W-1]};
   assign div_ge  = rem_sh >= {1'b0, den_ff};
   assign srem_sh = {srem_ff[SR_W-3:0], sq_ff[SQ_W-1:SQ_W-2]};
   assign trial   = {root_ff[RES_W-1:0], 2'b01};
   assign sq_ge   = srem_sh >= trial;
   assign root_rnd = root_ff + RT_W'(srem_ff > {1'b0, root_ff});

   always_comb begin
      st_in     = st_ff;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      weff_in   = weff_ff;
      p_in      = p_ff;
      smag_in   = smag_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      acc_in    = acc_ff;
      den_in    = den_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      sq_in     = sq_ff;
      srem_in   = srem_ff;
      root_in   = root_ff;
      res_in    = res_ff;
      status_in = status_ff;
      unique case (st_ff)
         F_IDLE: begin
            if (start) begin
               st_in = F_PREP;
            end
         end
         F_PREP: begin
            if (wtot < ONE_Q16) begin
               weff_in = ONE_Q16;
               p_in    = sums.p + P_W'(zsq);
            end else begin
               weff_in = wtot;
               p_in    = sums.p;
            end
            smag_in   = sums.s[S_W-1] ? SMAG_W'(-sums.s) : SMAG_W'(sums.s);
            op_in     = OP_DEN;
            status_in = ST_OK;
            st_in     = F_LNCH;
         end
         F_LNCH: begin
            unique case (op_ff)
               OP_DEN:  begin x_in = A_W'(weff_ff); y_in = SMAG_W'(weff_ff); end
               OP_CORR: begin x_in = A_W'(p_ff);    y_in = SMAG_W'(ddof);    end
               OP_NUM:  begin x_in = sums.a;        y_in = SMAG_W'(weff_ff); end
               OP_SSQ:  begin x_in = A_W'(smag_ff); y_in = smag_ff;          end
               default: begin x_in = '0;            y_in = '0;               end
            endcase
            acc_in = '0;
            cnt_in = IT_W'(SMAG_W - 1);
            st_in  = F_MUL;
         end
         F_MUL: begin
            acc_in = {acc_ff[PR_W-2:0], 1'b0} + (y_ff[SMAG_W-1] ? PR_W'(x_ff) : '0);
            y_in   = {y_ff[SMAG_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               st_in = F_POST;
            end
         end
         F_POST: begin
            op_in = op_ff + 1'b1;
            st_in = F_LNCH;
            unique case (op_ff)
               OP_DEN: den_in = DEN_W'(acc_ff);
               OP_CORR: begin
                  if (acc_ff >= PR_W'(den_ff)) begin
                     status_in = ST_UNDEF;
                     res_in    = '0;
                     st_in     = F_OUT;
                  end else begin
                     den_in = den_ff - DEN_W'(acc_ff);
                  end
               end
               OP_NUM: num_in = acc_ff;
               OP_SSQ: begin
                  num_in = (num_ff >= acc_ff) ? num_ff - acc_ff : '0;
                  rem_in = '0;
                  cnt_in = IT_W'(PR_W - 1);
                  st_in  = F_DIV;
               end
               default: st_in = F_IDLE;
            endcase
         end
         F_DIV: begin
            rem_in = div_ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
            num_in = {num_ff[PR_W-2:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               st_in = F_RND;
            end
         end
         F_RND: begin
            num_in = num_ff + PR_W'({rem_ff, 1'b0} >= {1'b0, den_ff});
            st_in  = F_FIN;
         end
         F_FIN: begin
            if (!root_mode) begin
               res_in = (|num_ff[PR_W-1:RES_W]) ? '1 : num_ff[RES_W-1:0];
               st_in  = F_OUT;
            end else if (|num_ff[PR_W-1:QS_W]) begin
               res_in = '1;
               st_in  = F_OUT;
            end else begin
               sq_in   = {num_ff[QS_W-1:0], {VAL_W{1'b0}}};
               srem_in = '0;
               root_in = '0;
               cnt_in  = IT_W'(RES_W - 1);
               st_in   = F_SQRT;
            end
         end
         F_SQRT: begin
            srem_in = sq_ge ? srem_sh - trial : srem_sh;
            root_in = {root_ff[RES_W-1:0], sq_ge};
            sq_in   = {sq_ff[SQ_W-3:0], 2'b00};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               st_in = F_SRND;
            end
         end
         F_SRND: begin
            res_in = root_rnd[RES_W] ? '1 : root_rnd[RES_W-1:0];
            st_in  = F_OUT;
         end
         F_OUT: st_in = F_IDLE;
         default: st_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
      end else begin
         st_ff <= st_in;
      end
      op_ff     <= op_in;
      cnt_ff    <= cnt_in;
      weff_ff   <= weff_in;
      p_ff      <= p_in;
      smag_ff   <= smag_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      acc_ff    <= acc_in;
      den_ff    <= den_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      sq_ff     <= sq_in;
      srem_ff   <= srem_in;
      root_ff   <= root_in;
      res_ff    <= res_in;
      status_ff <= status_in;
   end

   assign done   = (st_ff == F_OUT);
   assign result = res_ff;
   assign status = status_ff;

endmodule

[hdl/weighted_variance_engine.sv]
// ----------------------------------------------------------------------------
// weighted_variance_engine
// Weighted variance / standard deviation of a stored set, effective-n ddof.
// ----------------------------------------------------------------------------
//  channel | ports                | beat
//  --------+----------------------+-------------------------------------------
//  req     | req_t{valid,ready}   | tdata: value_sample, weight_sample; tlast
//  rsp     | rsp_t{valid,ready}   | tdata: stat_result; tuser: status_code
//  csr     | csr_we/index/wdata   | 0 ddof_correction, 1 root_mode
//
//  Load: one beat per cycle into the sample RAM.
//  Closing pass: one shared 32x32 multiplier walks the stored entries, then
//  shift-add products, a restoring divide and, in root mode, a square root
//  finish the result. Error sets skip these and go to the rsp register.
//  Synchronous reset; no RAM clear. req is held off from tlast until the
//  result is in the rsp register; a stalled rsp delays only the next close.
// ----------------------------------------------------------------------------
module weighted_variance_engine import wve_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ENTRY_W-1:0]   req_tdata,   // value_sample, weight_sample
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RES_W-1:0]     rsp_tdata,   // stat_result
   output logic [STAT_W-1:0]    rsp_tuser,   // status_code
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DDOF_W-1:0]    csr_wdata
);

   localparam logic [1:0] T_LOAD = 2'd0;
   localparam logic [1:0] T_ACC  = 2'd1;
   localparam logic [1:0] T_WAIT = 2'd2;
   localparam logic [1:0] T_FIN  = 2'd3;

   logic [1:0]          st_ff, st_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [TOT_W-1:0]    tot_ff, tot_in;
   logic [1:0]          err_ff, err_in;
   logic [STAT_W-1:0]   errst_ff, errst_in;
   logic [DDOF_W-1:0]   ddof_ff, ddof_in;
   logic                root_ff, root_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]   rsp_user_ff, rsp_user_in;

   logic                accept, full, store;
   logic signed [VAL_W-1:0] w_in;
   logic                acc_start, acc_done, fin_start, fin_done;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0]  rd_data;
   wve_sums_type        sums;
   logic [RES_W-1:0]    fin_result;
   logic [STAT_W-1:0]   fin_status;

   assign req_tready = (st_ff == T_LOAD);
   assign accept     = req_tvalid & req_tready;
   assign full       = (cnt_ff == CNT_W'(MAX_ITEMS));
   assign store      = accept & ~full;
   assign w_in       = req_tdata[ENTRY_W-1:VAL_W];

   always_comb begin
      st_in        = st_ff;
      cnt_in       = cnt_ff;
      tot_in       = tot_ff;
      err_in       = err_ff;
      errst_in     = errst_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      acc_start    = 1'b0;
      fin_start    = 1'b0;
      unique case (st_ff)
         T_LOAD: begin
            if (accept) begin
               err_in = err_ff | {full, store & w_in[VAL_W-1]};
               if (store) begin
                  cnt_in = cnt_ff + 1'b1;
                  if (w_in > 0) begin
                     tot_in = tot_ff + TOT_W'(w_in[VAL_W-2:0]);
                  end
               end
               if (req_tlast) begin
                  priority if (err_in[0]) begin
                     errst_in = ST_NEG;
                     st_in    = T_WAIT;
                  end else if (err_in[1]) begin
                     errst_in = ST_OVF;
                     st_in    = T_WAIT;
                  end else begin
                     errst_in  = ST_OK;
                     acc_start = 1'b1;
                     st_in     = T_ACC;
                  end
               end
            end
         end
         T_ACC: begin
            if (acc_done) begin
               st_in = T_WAIT;
            end
         end
         T_WAIT: begin
            if (!rsp_valid_ff) begin
               if (errst_ff != ST_OK) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_user_in  = errst_ff;
                  cnt_in       = '0;
                  tot_in       = '0;
                  err_in       = '0;
                  st_in        = T_LOAD;
               end else begin
                  fin_start = 1'b1;
                  st_in     = T_FIN;
               end
            end
         end
         T_FIN: begin
            if (fin_done) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = fin_result;
               rsp_user_in  = fin_status;
               cnt_in       = '0;
               tot_in       = '0;
               err_in       = '0;
               st_in        = T_LOAD;
            end
         end
         default: st_in = T_LOAD;
      endcase
   end

   always_comb begin
      ddof_in = ddof_ff;
      root_in = root_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DDOF: ddof_in = csr_wdata;
            REG_ROOT: root_in = csr_wdata[0];
            default:  ddof_in = ddof_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= T_LOAD;
         cnt_ff       <= '0;
         tot_ff       <= '0;
         err_ff       <= '0;
         errst_ff     <= ST_OK;
         ddof_ff      <= '0;
         root_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         tot_ff       <= tot_in;
         err_ff       <= err_in;
         errst_ff     <= errst_in;
         ddof_ff      <= ddof_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   wve_ram u_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wve_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .start   (acc_start),
      .n_items (cnt_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .sums    (sums),
      .done    (acc_done)
   );

   wve_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .start     (fin_start),
      .sums      (sums),
      .wtot      (tot_ff),
      .ddof      (ddof_ff),
      .root_mode (root_ff),
      .done      (fin_done),
      .result    (fin_result),
      .status    (fin_status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[hdl/wve_checker.sv]
// ----------------------------------------------------------------------------
// wve_checker
// Port-level checks on the engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "weighted_variance_engine_defines.svh"

module wve_checker import wve_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic [ENTRY_W-1:0]   req_tdata,
   input logic                 req_tlast,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [RES_W-1:0]     rsp_tdata,
   input logic [STAT_W-1:0]    rsp_tuser,
   input logic                 csr_we,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [DDOF_W-1:0]    csr_wdata
);

   `WVE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp beat changed while stalled")

   `WVE_ASSERT_IMPL(a_err_zero, rsp_tvalid && rsp_tuser != ST_OK, rsp_tdata == '0, "error beat carries nonzero result")

   `WVE_ASSERT_NEXT(a_close_busy, req_tvalid && req_tready && req_tlast, !req_tready, "req accepted right after tlast")

   `WVE_ASSERT_IMPL(a_reset_idle, $past(reset), !rsp_tvalid, "rsp valid right after reset")

endmodule

bind weighted_variance_engine wve_checker u_wve_checker (.*);

[tb/tb_weighted_variance_engine.sv]
// ----------------------------------------------------------------------------
// Weighted variance engine testbench
// Streams (value, weight) sets into the engine and checks every result beat
// against a wide-integer predictor of the exact Q32.32 variance / std
// deviation, covering extreme fields, errors, overflow and register settings.
// ----------------------------------------------------------------------------
module tb_weighted_variance_engine;
   import wve_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [RES_W-1:0]  stat;
      logic [STAT_W-1:0] code;
   } stat_beat_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [ENTRY_W-1:0]   req_tdata;
   logic                 req_tlast;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RES_W-1:0]     rsp_tdata;
   logic [STAT_W-1:0]    rsp_tuser;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DDOF_W-1:0]    csr_wdata;

   // predictor state
   logic [31:0]       value_mem [MAX_ITEMS];
   logic [31:0]       weight_mem [MAX_ITEMS];
   int unsigned       pairs_held;
   logic [63:0]       weight_sum;
   logic              neg_seen;
   logic              ovf_seen;
   logic [DDOF_W-1:0] ddof_q;
   logic              root_q;

   stat_beat_type stat_expected [$];
   int          error_count;
   int          beats_checked;
   int          sets_sent;
   int          pairs_sent;
   int          sender_idle;
   int          receiver_idle;
   longint      cycle_count;

   weighted_variance_engine u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic stat_beat_type close_set();
      stat_beat_type r;
      logic [255:0] spos, sneg, s, a, p, t, weff, num, den, v, c, q;
      logic [63:0]  mag, wu, z, weffv;
      longint       val, wt;
      spos = '0; sneg = '0; a = '0; p = '0;
      r.stat = '0;
      if (neg_seen) begin
         r.code = ST_NEG;
         return r;
      end
      if (ovf_seen) begin
         r.code = ST_OVF;
         return r;
      end
      for (int i = 0; i < pairs_held; i++) begin
         val = longint'(signed'(value_mem[i]));
         wt  = longint'(signed'(weight_mem[i]));
         if (wt <= 0) continue;
         wu  = wt;
         mag = (val < 0) ? -val : val;
         if (val < 0) sneg = sneg + 256'(mag * wu);
         else spos = spos + 256'(mag * wu);
         t = 256'(mag * mag);
         a = a + t * 256'(wu);
         p = p + 256'(wu * wu);
      end
      if (weight_sum < 64'd65536) begin
         z = 64'd65536 - weight_sum;
         weffv = 64'd65536;
         p = p + 256'(z * z);
      end else begin
         weffv = weight_sum;
      end
      weff = 256'(weffv);
      den = weff * weff;
      t = 256'(ddof_q) * p;
      if (t >= den) begin
         r.code = ST_UNDEF;
         return r;
      end
      den = den - t;
      s = (spos >= sneg) ? spos - sneg : sneg - spos;
      num = weff * a;
      t = s * s;
      num = (num >= t) ? num - t : '0;
      v = num / den;
      if (((num % den) << 1) >= den) v = v + 1;
      r.code = ST_OK;
      if (root_q) begin
         v = v << 32;
         q = '0;
         for (int k = 127; k >= 0; k--) begin
            c = q | (256'd1 << k);
            if (c * c <= v) q = c;
         end
         if (v - q * q > q) q = q + 1;
         v = q;
      end
      r.stat = (v[255:64] != '0) ? '1 : v[63:0];
      return r;
   endfunction

   function automatic void load_pair(logic [31:0] v, logic [31:0] w, logic last);
      if (pairs_held >= MAX_ITEMS) begin
         ovf_seen = 1'b1;
      end else begin
         value_mem[pairs_held]  = v;
         weight_mem[pairs_held] = w;
         pairs_held++;
         if (w[31]) neg_seen = 1'b1;
         else weight_sum = weight_sum + 64'(w);
      end
      if (last) begin
         stat_expected.push_back(close_set());
         pairs_held = 0;
         weight_sum = '0;
         neg_seen = 1'b0;
         ovf_seen = 1'b0;
      end
   endfunction

   task automatic send_pair(logic [31:0] v, logic [31:0] w, logic last);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {w, v};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      load_pair(v, w, last);
      pairs_sent++;
      if (last) sets_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (stat_expected.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [DDOF_W-1:0] data);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_DDOF) ddof_q = data;
      else root_q = data[0];
   endtask

   function automatic logic [31:0] rand_weight();
      int sel;
      sel = $urandom_range(99);
      if (sel < 10) return 32'd0;
      if (sel < 25) return $urandom_range(30000);
      if (sel < 85) return $urandom_range(1, 1 << 20);
      return $urandom & 32'h7FFF_FFFF;
   endfunction

   function automatic logic [31:0] rand_value();
      if ($urandom_range(1)) return $urandom;
      return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
   endfunction

   task automatic send_random_set(int n);
      int bad;
      logic [31:0] w;
      bad = ($urandom_range(99) < 6) ? $urandom_range(n - 1) : -1;
      for (int i = 0; i < n; i++) begin
         w = (i == bad) ? ($urandom | 32'h8000_0000) : rand_weight();
         send_pair(rand_value(), w, i == n - 1);
      end
   endtask

   task automatic test_field_extremes();
      send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      send_pair(32'h8000_0000, 32'h0000_0001, 1'b0);
      send_pair(32'hFFFF_FFFF, 32'h0001_0000, 1'b1);
      send_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
      send_pair(32'h5555_5555, 32'h2AAA_AAAA, 1'b0);
      send_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
   endtask

   task automatic test_special_sets();
      // all weights zero
      send_pair(32'h1234_5678, 32'h0, 1'b0);
      send_pair(32'h8765_4321, 32'h0, 1'b1);
      // total weight below one
      send_pair(32'h0003_0000, 32'h0000_4000, 1'b0);
      send_pair(32'hFFFD_0000, 32'h0000_2000, 1'b1);
      // negative weight, then negative on the closing beat
      send_pair(32'h0001_0000, 32'h8000_0000, 1'b0);
      send_pair(32'h0002_0000, 32'h0001_0000, 1'b1);
      send_pair(32'h0002_0000, 32'hFFFF_FFFF, 1'b1);
      // single pair
      send_pair(32'h0010_0000, 32'h0003_0000, 1'b1);
   endtask

   task automatic test_ddof_and_root();
      write_csr(REG_DDOF, 10'd1);
      send_pair(32'h0001_0000, 32'h0001_0000, 1'b0);
      send_pair(32'h0003_0000, 32'h0001_0000, 1'b1);
      send_pair(32'h0001_0000, 32'h0001_0000, 1'b1);
      write_csr(REG_ROOT, 10'd1);
      send_pair(32'h7FFF_FFFF, 32'h0001_0000, 1'b0);
      send_pair(32'h8000_0000, 32'h0001_0000, 1'b1);
      send_pair(32'h0001_0000, 32'h0001_0000, 1'b0);
      send_pair(32'h0003_0000, 32'h0002_0000, 1'b1);
      write_csr(REG_DDOF, 10'd1023);
      send_pair(32'h0001_0000, 32'h0001_0000, 1'b0);
      send_pair(32'h0009_0000, 32'h0001_0000, 1'b1);
      write_csr(REG_DDOF, 10'd0);
      write_csr(REG_ROOT, 10'd0);
   endtask

   task automatic test_buffer_overflow();
      // closing beat arrives with the store full and is dropped
      for (int i = 0; i < MAX_ITEMS + 1; i++)
         send_pair(rand_value(), rand_weight(), i == MAX_ITEMS);
   endtask

   task automatic test_random_phase(int s_idle, int r_idle, int pairs);
      int goal;
      logic [DDOF_W-1:0] d;
      sender_idle   = s_idle;
      receiver_idle = r_idle;
      goal = pairs_sent + pairs;
      while (pairs_sent < goal) begin
         if ($urandom_range(24) == 0) begin
            case ($urandom_range(3))
               0: d = 10'd0;
               1: d = 10'd1;
               2: d = 10'd1023;
               default: d = DDOF_W'($urandom_range(1023));
            endcase
            write_csr(REG_DDOF, d);
            write_csr(REG_ROOT, DDOF_W'($urandom_range(1)));
         end
         if ($urandom_range(39) == 0) drain();
         send_random_set(($urandom_range(19) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8));
      end
   endtask

   always @(posedge clock) begin
      stat_beat_type exp_beat;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle);
         if (rsp_tvalid && rsp_tready) begin
            beats_checked++;
            if (stat_expected.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result beat stat=%h status=%0d",
                        $realtime, rsp_tdata, rsp_tuser);
            end else begin
               exp_beat = stat_expected.pop_front();
               if (rsp_tdata !== exp_beat.stat) begin
                  error_count++;
                  $display("%0t: stat_result expected %h actual %h",
                           $realtime, exp_beat.stat, rsp_tdata);
               end
               if (rsp_tuser !== exp_beat.code) begin
                  error_count++;
                  $display("%0t: status_code expected %0d actual %0d",
                           $realtime, exp_beat.code, rsp_tuser);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0; csr_index = REG_DDOF; csr_wdata = '0;
      cycle_count = 0; error_count = 0; beats_checked = 0;
      sets_sent = 0; pairs_sent = 0;
      pairs_held = 0; weight_sum = '0; neg_seen = 1'b0; ovf_seen = 1'b0;
      ddof_q = '0; root_q = 1'b0;
      sender_idle = 33; receiver_idle = 82;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_special_sets();
      test_ddof_and_root();
      test_buffer_overflow();
      test_random_phase(33, 82, 170);
      test_random_phase(82, 33, 170);
      test_random_phase(0, 0, 170);
      drain();
      repeat (200) @(posedge clock);
      $display("sent %0d pairs in %0d sets, checked %0d result beats", pairs_sent,
               sets_sent, beats_checked);
      $display("covered ddof 0..1023, variance and root modes, errors and overflow");
      if (error_count == 0 && stat_expected.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
